[rtl/hsv_window_point_classifier_unit_defines.svh]
// Assertion macros shared by the checker of the HSV window point classifier.
`ifndef HSV_WINDOW_POINT_CLASSIFIER_UNIT_DEFINES_SVH
`define HSV_WINDOW_POINT_CLASSIFIER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HSVC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsvc: same-cycle check failed");

// Checks that the consequent holds a fixed number of cycles after the antecedent.
`define HSVC_ASSERT_AFTER(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("hsvc: delayed check failed");

`endif

[rtl/hsvc_pkg.sv]
// Types and constants shared by the HSV window point classifier modules.
`default_nettype none

package hsvc_pkg;

    localparam int COLOR_W = 8;
    localparam int COORD_W = 32;
    localparam int HUE_W   = 12;
    localparam int PCT_W   = 10;

    // Hue arithmetic in tenths of a degree: one sixth of the circle is 600.
    localparam int HUE_SECTOR = 600;
    localparam logic [HUE_W-1:0] HUE_WRAP       = 12'd3600;
    localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 12'd2400;
    localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 12'd1200;
    localparam logic [HUE_W-1:0] HUE_RED_BASE   = 12'd0;
    localparam int PERMILLE   = 1000;

    // Divider: 20-bit dividend, 8-bit divisor, 12 quotient bits, two per stage.
    localparam int DIV_NUM_W   = 20;
    localparam int DIV_DEN_W   = 8;
    localparam int DIV_Q_W     = 12;
    localparam int DIV_BPS     = 2;
    localparam int DIV_STAGES  = DIV_Q_W / DIV_BPS;
    localparam int VAL_X_W     = 18;
    localparam int VAL_CALC_STAGES = 3;
    localparam int FRONT_STAGES = 2;
    localparam int CORE_LAT    = FRONT_STAGES + DIV_STAGES;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_LOW_A  = 4'd0,
        CFG_HUE_HIGH_A = 4'd1,
        CFG_HUE_LOW_B  = 4'd2,
        CFG_HUE_HIGH_B = 4'd3,
        CFG_SAT_LOW    = 4'd4,
        CFG_SAT_HIGH   = 4'd5,
        CFG_VAL_LOW    = 4'd6,
        CFG_VAL_HIGH   = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0] red_in;
        logic [COLOR_W-1:0] green_in;
        logic [COLOR_W-1:0] blue_in;
        logic [COORD_W-1:0] coord_x_in;
        logic [COORD_W-1:0] coord_y_in;
        logic [COORD_W-1:0] coord_z_in;
    } t_in;

    typedef struct packed {
        logic               inside_res;
        logic [HUE_W-1:0]   hue;
        logic [PCT_W-1:0]   saturation;
        logic [PCT_W-1:0]   brightness;
        logic [COLOR_W-1:0] red_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] blue_out;
        logic [COORD_W-1:0] coord_x_out;
        logic [COORD_W-1:0] coord_y_out;
        logic [COORD_W-1:0] coord_z_out;
    } t_out;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_op;

    typedef struct packed {
        t_div_op            hue_op;
        t_div_op            sat_op;
        logic [VAL_X_W-1:0] val_x;
    } t_front;

    typedef struct packed {
        logic [HUE_W-1:0] hue_low_a;
        logic [HUE_W-1:0] hue_high_a;
        logic [HUE_W-1:0] hue_low_b;
        logic [HUE_W-1:0] hue_high_b;
        logic [PCT_W-1:0] sat_low;
        logic [PCT_W-1:0] sat_high;
        logic [PCT_W-1:0] val_low;
        logic [PCT_W-1:0] val_high;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        hue_low_a:  12'd0,
        hue_high_a: 12'd3599,
        hue_low_b:  12'd0,
        hue_high_b: 12'd3599,
        sat_low:    10'd0,
        sat_high:   10'd1000,
        val_low:    10'd0,
        val_high:   10'd1000
    };

endpackage

`default_nettype wire

[rtl/hsv_window_point_classifier_unit.sv]
// Throughput: one point per cycle; busy never rises, a point may be started every cycle.
// A point passes through a two-stage front end, the six-stage restoring divider (two
// quotient bits per stage) and the output register, which holds result and strobe.
// Reset (synchronous, active low) empties the pipeline and loads the default windows.
`default_nettype none

module hsv_window_point_classifier_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  hsvc_pkg::t_in                      i_point,
    output logic                               o_strobe,
    output hsvc_pkg::t_out                     o_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hsvc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hsvc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int LAT = hsvc_pkg::CORE_LAT;

    hsvc_pkg::t_cfg                 r_cfg;
    logic [LAT-1:0]                 r_valid;
    hsvc_pkg::t_in                  r_pass [LAT];
    hsvc_pkg::t_front               w_front;
    logic [hsvc_pkg::DIV_Q_W-1:0]   w_hue_q;
    logic [hsvc_pkg::DIV_Q_W-1:0]   w_sat_q;
    logic [hsvc_pkg::PCT_W-1:0]     w_val;
    logic                           w_accept;
    logic                           w_hue_ok;
    logic                           w_sat_ok;
    logic                           w_val_ok;
    hsvc_pkg::t_out                 n_result;
    hsvc_pkg::t_out                 r_result;
    logic                           r_strobe;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= hsvc_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                hsvc_pkg::CFG_HUE_LOW_A:  r_cfg.hue_low_a  <= i_cfg_data[hsvc_pkg::HUE_W-1:0];
                hsvc_pkg::CFG_HUE_HIGH_A: r_cfg.hue_high_a <= i_cfg_data[hsvc_pkg::HUE_W-1:0];
                hsvc_pkg::CFG_HUE_LOW_B:  r_cfg.hue_low_b  <= i_cfg_data[hsvc_pkg::HUE_W-1:0];
                hsvc_pkg::CFG_HUE_HIGH_B: r_cfg.hue_high_b <= i_cfg_data[hsvc_pkg::HUE_W-1:0];
                hsvc_pkg::CFG_SAT_LOW:    r_cfg.sat_low    <= i_cfg_data[hsvc_pkg::PCT_W-1:0];
                hsvc_pkg::CFG_SAT_HIGH:   r_cfg.sat_high   <= i_cfg_data[hsvc_pkg::PCT_W-1:0];
                hsvc_pkg::CFG_VAL_LOW:    r_cfg.val_low    <= i_cfg_data[hsvc_pkg::PCT_W-1:0];
                hsvc_pkg::CFG_VAL_HIGH:   r_cfg.val_high   <= i_cfg_data[hsvc_pkg::PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hsvc_front u_front (
        .i_clk   (i_clk),
        .i_red   (i_point.red_in),
        .i_green (i_point.green_in),
        .i_blue  (i_point.blue_in),
        .o_front (w_front)
    );

    hsvc_div u_hue_div (
        .i_clk  (i_clk),
        .i_op   (w_front.hue_op),
        .o_quot (w_hue_q)
    );

    hsvc_div u_sat_div (
        .i_clk  (i_clk),
        .i_op   (w_front.sat_op),
        .o_quot (w_sat_q)
    );

    hsvc_val u_val (
        .i_clk (i_clk),
        .i_x   (w_front.val_x),
        .o_val (w_val)
    );

    // The original color and coordinates ride alongside the arithmetic.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[LAT-2:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pass[0] <= i_point;
        for (int i = 1; i < LAT; i++) begin
            r_pass[i] <= r_pass[i-1];
        end
    end

    always_comb begin
        w_hue_ok = (w_hue_q >= r_cfg.hue_low_a && w_hue_q <= r_cfg.hue_high_a)
                || (w_hue_q >= r_cfg.hue_low_b && w_hue_q <= r_cfg.hue_high_b);
        w_sat_ok = w_sat_q[hsvc_pkg::PCT_W-1:0] >= r_cfg.sat_low
                && w_sat_q[hsvc_pkg::PCT_W-1:0] <= r_cfg.sat_high;
        w_val_ok = w_val >= r_cfg.val_low && w_val <= r_cfg.val_high;

        n_result.inside_res  = w_hue_ok && w_sat_ok && w_val_ok;
        n_result.hue         = w_hue_q;
        n_result.saturation  = w_sat_q[hsvc_pkg::PCT_W-1:0];
        n_result.brightness  = w_val;
        n_result.red_out     = r_pass[LAT-1].red_in;
        n_result.green_out   = r_pass[LAT-1].green_in;
        n_result.blue_out    = r_pass[LAT-1].blue_in;
        n_result.coord_x_out = r_pass[LAT-1].coord_x_in;
        n_result.coord_y_out = r_pass[LAT-1].coord_y_in;
        n_result.coord_z_out = r_pass[LAT-1].coord_z_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_valid[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

[rtl/hsvc_front.sv]
// Front end: max, min, chroma, hue sector and the dividends of the three quotients.
`default_nettype none

module hsvc_front (
    input  logic                              i_clk,
    input  logic [hsvc_pkg::COLOR_W-1:0]      i_red,
    input  logic [hsvc_pkg::COLOR_W-1:0]      i_green,
    input  logic [hsvc_pkg::COLOR_W-1:0]      i_blue,
    output hsvc_pkg::t_front                  o_front
);

    localparam int HACC_W = 22;

    logic [hsvc_pkg::COLOR_W-1:0] w_mx;
    logic [hsvc_pkg::COLOR_W-1:0] w_mn;
    logic [hsvc_pkg::HUE_W-1:0]   w_base;
    logic [hsvc_pkg::COLOR_W-1:0] w_p;
    logic [hsvc_pkg::COLOR_W-1:0] w_q;

    logic [hsvc_pkg::COLOR_W-1:0] r_mx;
    logic [hsvc_pkg::COLOR_W-1:0] r_c;
    logic [hsvc_pkg::HUE_W-1:0]   r_base;
    logic [hsvc_pkg::COLOR_W-1:0] r_p;
    logic [hsvc_pkg::COLOR_W-1:0] r_q;

    logic [HACC_W-1:0]            w_hue_acc;
    hsvc_pkg::t_front             n_front;
    hsvc_pkg::t_front             r_front;

    // Stage A: pick the sector. The hue numerator is base*c + 600*(p - q).
    always_comb begin
        w_mx = (i_red > i_green) ? i_red : i_green;
        if (i_blue > w_mx) begin
            w_mx = i_blue;
        end
        w_mn = (i_red < i_green) ? i_red : i_green;
        if (i_blue < w_mn) begin
            w_mn = i_blue;
        end
        if (w_mx == i_red && w_mx != i_green && w_mx != i_blue) begin
            w_base = (i_green >= i_blue) ? hsvc_pkg::HUE_RED_BASE : hsvc_pkg::HUE_WRAP;
            w_p    = i_green;
            w_q    = i_blue;
        end else if (w_mx == i_blue && w_mx != i_green) begin
            w_base = hsvc_pkg::HUE_BLUE_BASE;
            w_p    = i_red;
            w_q    = i_green;
        end else begin
            w_base = hsvc_pkg::HUE_GREEN_BASE;
            w_p    = i_blue;
            w_q    = i_red;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx   <= w_mx;
        r_c    <= w_mx - w_mn;
        r_base <= w_base;
        r_p    <= w_p;
        r_q    <= w_q;
    end

    // Stage B: dividends. A zero divisor is replaced by 0/1 so the quotient is 0.
    always_comb begin
        w_hue_acc = HACC_W'(r_base) * HACC_W'(r_c)
                  + HACC_W'(hsvc_pkg::HUE_SECTOR) * HACC_W'(r_p)
                  - HACC_W'(hsvc_pkg::HUE_SECTOR) * HACC_W'(r_q);
        if (r_c == '0) begin
            n_front.hue_op.num = '0;
            n_front.hue_op.den = hsvc_pkg::DIV_DEN_W'(1);
        end else begin
            n_front.hue_op.num = w_hue_acc[hsvc_pkg::DIV_NUM_W-1:0];
            n_front.hue_op.den = r_c;
        end
        n_front.sat_op.num = hsvc_pkg::DIV_NUM_W'(r_c) * hsvc_pkg::DIV_NUM_W'(hsvc_pkg::PERMILLE);
        n_front.sat_op.den = (r_mx == '0) ? hsvc_pkg::DIV_DEN_W'(1) : r_mx;
        n_front.val_x      = hsvc_pkg::VAL_X_W'(r_mx) * hsvc_pkg::VAL_X_W'(hsvc_pkg::PERMILLE);
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
    end

    assign o_front = r_front;

endmodule

`default_nettype wire

[rtl/hsvc_div.sv]
// Pipelined restoring divider, two quotient bits per register stage.
`default_nettype none

module hsvc_div (
    input  logic                          i_clk,
    input  hsvc_pkg::t_div_op             i_op,
    output logic [hsvc_pkg::DIV_Q_W-1:0]  o_quot
);

    localparam int NUM_W  = hsvc_pkg::DIV_NUM_W;
    localparam int DEN_W  = hsvc_pkg::DIV_DEN_W;
    localparam int Q_W    = hsvc_pkg::DIV_Q_W;
    localparam int BPS    = hsvc_pkg::DIV_BPS;
    localparam int STAGES = hsvc_pkg::DIV_STAGES;
    localparam int SH_W   = NUM_W + 1;

    logic [NUM_W-1:0] r_rem  [STAGES];
    logic [DEN_W-1:0] r_den  [STAGES];
    logic [Q_W-1:0]   r_quot [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [NUM_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [Q_W-1:0]   w_quot_in;
        logic [SH_W-1:0]  w_trial;
        logic [SH_W-1:0]  w_rem;
        logic [Q_W-1:0]   n_quot;

        if (s == 0) begin : g_first
            assign w_rem_in  = i_op.num;
            assign w_den_in  = i_op.den;
            assign w_quot_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_den_in  = r_den[s-1];
            assign w_quot_in = r_quot[s-1];
        end

        // The dividend is always below den * 2**Q_W, so no quotient bit is lost.
        always_comb begin
            w_rem  = {1'b0, w_rem_in};
            n_quot = w_quot_in;
            w_trial = '0;
            for (int k = 0; k < BPS; k++) begin
                w_trial = {{(SH_W-DEN_W){1'b0}}, w_den_in} << (Q_W - 1 - s*BPS - k);
                if (w_rem >= w_trial) begin
                    w_rem = w_rem - w_trial;
                    n_quot[Q_W - 1 - s*BPS - k] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= w_rem[NUM_W-1:0];
            r_den[s]  <= w_den_in;
            r_quot[s] <= n_quot;
        end
    end

    assign o_quot = r_quot[STAGES-1];

endmodule

`default_nettype wire

[rtl/hsvc_val.sv]
// Value channel: divides by 255 through a reciprocal and a correction, then aligns.
`default_nettype none

module hsvc_val (
    input  logic                          i_clk,
    input  logic [hsvc_pkg::VAL_X_W-1:0]  i_x,
    output logic [hsvc_pkg::PCT_W-1:0]    o_val
);

    localparam int X_W     = hsvc_pkg::VAL_X_W;
    localparam int Q_W     = hsvc_pkg::PCT_W;
    localparam int PROD_W  = X_W + 9;
    localparam int RSHIFT  = 16;
    localparam int REM_W   = 9;
    localparam int DLY     = hsvc_pkg::DIV_STAGES - hsvc_pkg::VAL_CALC_STAGES;
    localparam logic [8:0] RECIP  = 9'd257;
    localparam logic [7:0] DIVSOR = 8'd255;

    logic [PROD_W-1:0] w_prod;
    logic [X_W-1:0]    w_diff;

    logic [X_W-1:0]    r_x1;
    logic [Q_W-1:0]    r_est1;
    logic [Q_W-1:0]    r_est2;
    logic [REM_W-1:0]  r_rem2;
    logic [Q_W-1:0]    r_q3;
    logic [Q_W-1:0]    r_dly [DLY];

    // x*257/65536 is at most one below x/255 over the whole input range.
    assign w_prod = PROD_W'(i_x) * PROD_W'(RECIP);
    assign w_diff = r_x1 - X_W'(r_est1) * X_W'(DIVSOR);

    always_ff @(posedge i_clk) begin
        r_x1   <= i_x;
        r_est1 <= w_prod[RSHIFT +: Q_W];
        r_est2 <= r_est1;
        r_rem2 <= w_diff[REM_W-1:0];
        r_q3   <= (r_rem2 >= REM_W'(DIVSOR)) ? r_est2 + Q_W'(1) : r_est2;
        r_dly[0] <= r_q3;
        for (int i = 1; i < DLY; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    assign o_val = r_dly[DLY-1];

endmodule

`default_nettype wire

[rtl/hsvc_checker.sv]
// Port-level checker for the HSV window point classifier and its bind.
`default_nettype none
`include "hsv_window_point_classifier_unit_defines.svh"

module hsvc_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             o_strobe,
    input  hsvc_pkg::t_out   o_result
);

    logic w_grey;
    logic w_no_hue_sat;
    logic w_in_range;

    assign w_grey       = o_result.red_out == o_result.green_out
                       && o_result.green_out == o_result.blue_out;
    assign w_no_hue_sat = o_result.hue == 12'd0 && o_result.saturation == 10'd0;
    assign w_in_range   = o_result.hue <= 12'd3599 && o_result.saturation <= 10'd1000
                       && o_result.brightness <= 10'd1000;

    // Every accepted transaction is followed by a result strobe.
    `HSVC_ASSERT_AFTER(a_latency, i_clk, i_rst_n, start && !busy, 9, o_strobe)

    // No result appears without an earlier accepted transaction.
    `HSVC_ASSERT_NOW(a_no_spurious, i_clk, i_rst_n, o_strobe, $past(start && !busy, 9))

    // A grey or black point has neither hue nor saturation.
    `HSVC_ASSERT_NOW(a_grey, i_clk, i_rst_n, o_strobe && w_grey, w_no_hue_sat)

    // Results stay within the ranges of the color space.
    `HSVC_ASSERT_NOW(a_range, i_clk, i_rst_n, o_strobe, w_in_range)

endmodule

bind hsv_window_point_classifier_unit hsvc_checker u_hsvc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire
